// ----- src/isotp_pkg.sv -----
// ----------------------------------------------------------------------------
// isotp_pkg
// Shared types and constants for the ISO-TP receive reassembler.
// ----------------------------------------------------------------------------
package isotp_pkg;

    localparam int MAX_MESSAGE = 4095;
    localparam int LEN_W       = 12;
    localparam int IN_DATA_W   = 72;
    localparam int OUT_DATA_W  = 72;
    localparam int OUT_USER_W  = 4;

    // queue depth, power of two
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    localparam logic [LEN_W-1:0] CAP_RESET = LEN_W'(MAX_MESSAGE);

    localparam logic [7:0] TYPE_MASK   = 8'hf0;
    localparam logic [7:0] TYPE_SINGLE = 8'h00;
    localparam logic [7:0] TYPE_FIRST  = 8'h10;
    localparam logic [7:0] TYPE_CONSEC = 8'h20;
    localparam logic [3:0] LOW_NIBBLE  = 4'h0f;

    localparam logic [3:0] FRAME_MAX   = 4'd8;
    localparam logic [2:0] SF_MAX_DATA = 3'd7;
    localparam logic [2:0] FF_DATA     = 3'd6;
    localparam logic [2:0] CF_MAX_DATA = 3'd7;
    localparam logic [3:0] SEQ_START   = 4'd1;

    typedef enum logic [1:0] {
        ST_PROGRESS = 2'd0,
        ST_DONE     = 2'd1,
        ST_ERROR    = 2'd2,
        ST_TOO_LONG = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        FLOW_NONE     = 2'd0,
        FLOW_CTS      = 2'd1,
        FLOW_OVERFLOW = 2'd2
    } t_flow;

    typedef enum logic [1:0] {
        PH_IDLE = 2'b01,
        PH_RECV = 2'b10
    } t_phase;

    // classified frame; data[0] is frame byte 1
    typedef struct packed {
        logic [3:0]       len;
        logic [6:0][7:0]  data;
        logic             consec;
        logic [3:0]       seq;
        t_status          idle_status;
        t_flow            idle_flow;
        logic [2:0]       idle_count;
        logic [LEN_W-1:0] idle_len;
        logic             idle_from2;
        logic             idle_open;
    } t_info;

    typedef struct packed {
        logic [6:0][7:0]  data;
        logic [2:0]       count;
        t_status          status;
        t_flow            flow;
        logic [LEN_W-1:0] msg_len;
    } t_result;

endpackage

// ----- src/isotp_front.sv -----
// ----------------------------------------------------------------------------
// isotp_front
// Accepts CAN frames and classifies them ahead of the reassembly state.
// ----------------------------------------------------------------------------
module isotp_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [isotp_pkg::LEN_W-1:0]     i_cfg_wdata,
    input  logic                           i_tvalid,
    output logic                           o_tready,
    input  logic [isotp_pkg::IN_DATA_W-1:0] i_tdata,
    input  logic                           i_q_full,
    output logic                           o_push,
    output isotp_pkg::t_info                o_info
);
    import isotp_pkg::*;

    logic [LEN_W-1:0] r_cap;
    logic [3:0]       len_raw;
    logic [3:0]       len;
    logic [7:0]       b0;
    logic [7:0]       ftype;
    logic [6:0][7:0]  data;
    logic [3:0]       sf_total;
    logic [LEN_W-1:0] ff_total;
    t_info            info;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_wdata;
        end
    end

    always_comb begin
        len_raw = i_tdata[3:0];
        len     = (len_raw > FRAME_MAX) ? FRAME_MAX : len_raw;
        b0      = i_tdata[11:4];
        for (int k = 0; k < 7; k++) begin
            data[k] = i_tdata[12 + 8*k +: 8];
        end
        ftype    = b0 & TYPE_MASK;
        sf_total = b0[3:0] & LOW_NIBBLE;
        ff_total = {b0[3:0], data[0]};

        info.len         = len;
        info.data        = data;
        info.consec      = (ftype == TYPE_CONSEC);
        info.seq         = b0[3:0];
        info.idle_status = ST_ERROR;
        info.idle_flow   = FLOW_NONE;
        info.idle_count  = 3'd0;
        info.idle_len    = '0;
        info.idle_from2  = 1'b0;
        info.idle_open   = 1'b0;

        priority if (len == 4'd0) begin
            info.idle_status = ST_ERROR;
        end else if (ftype == TYPE_SINGLE) begin
            priority if (sf_total > {1'b0, SF_MAX_DATA} ||
                         {1'b0, len} < {1'b0, sf_total} + 5'd1) begin
                info.idle_status = ST_ERROR;
            end else if (LEN_W'(sf_total) > r_cap) begin
                info.idle_status = ST_TOO_LONG;
                info.idle_len    = LEN_W'(sf_total);
            end else begin
                info.idle_status = ST_DONE;
                info.idle_count  = sf_total[2:0];
                info.idle_len    = LEN_W'(sf_total);
            end
        end else if (ftype == TYPE_FIRST) begin
            priority if (len < FRAME_MAX) begin
                info.idle_status = ST_ERROR;
            end else if (ff_total <= LEN_W'(SF_MAX_DATA) ||
                         ff_total > LEN_W'(MAX_MESSAGE) || ff_total > r_cap) begin
                info.idle_status = ST_TOO_LONG;
                info.idle_flow   = FLOW_OVERFLOW;
                info.idle_len    = ff_total;
                info.idle_from2  = 1'b1;
            end else begin
                info.idle_status = ST_PROGRESS;
                info.idle_flow   = FLOW_CTS;
                info.idle_count  = FF_DATA;
                info.idle_len    = ff_total;
                info.idle_from2  = 1'b1;
                info.idle_open   = 1'b1;
            end
        end else begin
            info.idle_status = ST_ERROR;
        end
    end

    assign o_tready = !i_q_full;
    assign o_push   = i_tvalid && !i_q_full;
    assign o_info   = info;

endmodule

// ----- src/isotp_queue.sv -----
// ----------------------------------------------------------------------------
// isotp_queue
// Short queue of classified frames between front and back.
// ----------------------------------------------------------------------------
module isotp_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  isotp_pkg::t_info i_data,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_pop,
    output isotp_pkg::t_info o_data
);
    import isotp_pkg::*;

    t_info           r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wptr;
    logic [Q_AW-1:0] r_rptr;
    logic [Q_AW:0]   r_cnt;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ----- src/isotp_back.sv -----
// ----------------------------------------------------------------------------
// isotp_back
// Reassembly state and registered result stage.
// ----------------------------------------------------------------------------
module isotp_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  isotp_pkg::t_info   i_q_data,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output isotp_pkg::t_result o_result
);
    import isotp_pkg::*;

    t_phase           r_phase, n_phase;
    logic [LEN_W-1:0] r_total, n_total;
    logic [LEN_W-1:0] r_rcvd, n_rcvd;
    logic [3:0]       r_nseq, n_nseq;
    logic             r_valid;
    t_result          r_res, n_res;

    logic [LEN_W-1:0] diff;
    logic [2:0]       chunk;
    logic [LEN_W-1:0] sum;
    logic             cf_ok;
    logic             from2;
    logic [7:0]       pick;

    assign o_pop = i_q_valid && (!r_valid || i_ready);

    always_comb begin
        n_phase = r_phase;
        n_total = r_total;
        n_rcvd  = r_rcvd;
        n_nseq  = r_nseq;
        n_res   = '0;
        from2   = 1'b0;
        diff    = r_total - r_rcvd;
        chunk   = (diff > LEN_W'(CF_MAX_DATA)) ? CF_MAX_DATA : diff[2:0];
        sum     = r_rcvd + LEN_W'(chunk);
        cf_ok   = i_q_data.consec && (i_q_data.seq == r_nseq) &&
                  (i_q_data.len >= {1'b0, chunk} + 4'd1);

        unique case (r_phase)
            PH_IDLE: begin
                n_res.count   = i_q_data.idle_count;
                n_res.status  = i_q_data.idle_status;
                n_res.flow    = i_q_data.idle_flow;
                n_res.msg_len = i_q_data.idle_len;
                from2         = i_q_data.idle_from2;
                if (i_q_data.idle_open) begin
                    n_phase = PH_RECV;
                    n_total = i_q_data.idle_len;
                    n_rcvd  = LEN_W'(FF_DATA);
                    n_nseq  = SEQ_START;
                end
            end
            PH_RECV: begin
                n_res.msg_len = r_total;
                n_res.flow    = FLOW_NONE;
                if (!cf_ok) begin
                    n_res.status = ST_ERROR;
                    n_phase      = PH_IDLE;
                    n_total      = '0;
                    n_rcvd       = '0;
                    n_nseq       = SEQ_START;
                end else begin
                    n_res.count = chunk;
                    if (sum >= r_total) begin
                        n_res.status = ST_DONE;
                        n_phase      = PH_IDLE;
                        n_total      = '0;
                        n_rcvd       = '0;
                        n_nseq       = SEQ_START;
                    end else begin
                        n_res.status = ST_PROGRESS;
                        n_rcvd       = sum;
                        n_nseq       = r_nseq + 4'd1;
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase

        for (int k = 0; k < 7; k++) begin
            if (from2) begin
                pick = (k < 6) ? i_q_data.data[(k < 6) ? k + 1 : 0] : 8'd0;
            end else begin
                pick = i_q_data.data[k];
            end
            n_res.data[k] = (3'(k) < n_res.count) ? pick : 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_total <= '0;
            r_rcvd  <= '0;
            r_nseq  <= SEQ_START;
            r_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase <= n_phase;
                r_total <= n_total;
                r_rcvd  <= n_rcvd;
                r_nseq  <= n_nseq;
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res <= n_res;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_res;

    a_recv_short : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_RECV |-> r_rcvd < r_total)
        else $error("receiving with count at or above total");

    a_idle_clear : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_IDLE |-> r_rcvd == '0 && r_total == '0 && r_nseq == SEQ_START)
        else $error("idle state not cleared");

    a_err_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_res.status == ST_ERROR |-> r_res.count == 3'd0 &&
        r_res.flow == FLOW_NONE)
        else $error("error result carries bytes or flow request");

    a_open : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && r_phase == PH_IDLE && i_q_data.idle_open |=>
        r_phase == PH_RECV && r_rcvd == LEN_W'(FF_DATA) && r_res.flow == FLOW_CTS)
        else $error("first frame did not open reception");

    a_overflow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_res.flow == FLOW_OVERFLOW |-> r_res.status == ST_TOO_LONG)
        else $error("overflow request without too-long status");

endmodule

// ----- src/isotp_rx_reassembler_unit.sv -----
// ----------------------------------------------------------------------------
// isotp_rx_reassembler_unit
// ISO 15765-2 receive reassembly of classic CAN frames.
//
// Slave stream: one CAN frame per transfer. s_axis_tdata fields from bit 0:
//   frame_length[3:0], frame_byte_0 .. frame_byte_7, 4 zero bits of padding.
// Master stream: one result per frame. m_axis_tdata carries the payload
//   bytes, their count and the message length; m_axis_tuser carries the
//   status and the flow-control request.
// Config: i_cfg_we writes receive_capacity from i_cfg_wdata; reset 4095.
// Each frame passes through the queue and the output register to become a result.
// Throughput: one frame per cycle while the master accepts results; the front classifies frames into a
//   2-entry queue, the back applies them to the reassembly state and holds
//   the result in an output register.
// Reset: idle phase, empty queue, no pending result.
// A stalled master holds the output register; the queue takes up to two
//   more frames before s_axis_tready drops.
// ----------------------------------------------------------------------------
module isotp_rx_reassembler_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [isotp_pkg::LEN_W-1:0]         i_cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // frame_length, frame_byte_0 .. frame_byte_7, padding
    input  logic [isotp_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // out_byte_0 .. out_byte_6, out_count, message_length, padding
    output logic [isotp_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // status, flow_request
    output logic [isotp_pkg::OUT_USER_W-1:0]    m_axis_tuser
);
    import isotp_pkg::*;

    t_info   fr_info;
    logic    fr_push;
    logic    q_full;
    logic    q_valid;
    t_info   q_data;
    logic    q_pop;
    t_result res;

    isotp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_tvalid    (s_axis_tvalid),
        .o_tready    (s_axis_tready),
        .i_tdata     (s_axis_tdata),
        .i_q_full    (q_full),
        .o_push      (fr_push),
        .o_info      (fr_info)
    );

    isotp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fr_push),
        .i_data  (fr_info),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (q_data)
    );

    isotp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_data),
        .o_pop     (q_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_result  (res)
    );

    assign m_axis_tdata = {1'b0, res.msg_len, res.count, res.data};
    assign m_axis_tuser = {res.flow, res.status};

endmodule

// ----- dv/tb_isotp_rx_reassembler_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_isotp_rx_reassembler_unit
// Self-checking bench for the ISO-TP receive reassembler. Frames go in as
// directed cases, capacity sweeps, one maximum-length message, a long output
// stall and mostly well-formed random messages with damaged frames and
// noise mixed in. A frame-level predictor tracks the reassembly state and
// every result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_isotp_rx_reassembler_unit;
    import isotp_pkg::*;

    localparam int HOLD_CYCLES = 40;
    localparam int STALL_LIMIT = 1000;

    typedef struct packed {
        logic [7:0][7:0] bytes;
        logic [3:0]      len;
    } t_frame;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [LEN_W-1:0]      i_cfg_wdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [OUT_USER_W-1:0] m_axis_tuser;

    // reassembly state as the block should hold it
    logic [LEN_W-1:0] rx_capacity;
    logic             rx_active;
    logic [LEN_W-1:0] rx_total;
    logic [LEN_W-1:0] rx_got;
    logic [3:0]       rx_seq;

    t_result pending_results[$];
    int      items_sent;
    int      fail_count;
    int      stall_cycles;
    bit      tx_gaps;
    bit      rx_gaps;
    bit      hold_off;

    isotp_rx_reassembler_unit i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    function automatic void go_idle();
        rx_active = 1'b0;
        rx_total  = '0;
        rx_got    = '0;
        rx_seq    = SEQ_START;
    endfunction

    function automatic t_result predict_frame(input t_frame f);
        t_result    r;
        logic [3:0] n;
        logic [3:0] nib;
        logic [7:0] kind;
        logic [LEN_W-1:0] total;
        logic [LEN_W-1:0] due;
        int         from;
        r    = '0;
        from = 1;
        n    = (f.len > FRAME_MAX) ? FRAME_MAX : f.len;
        nib  = f.bytes[0][3:0];
        kind = f.bytes[0] & TYPE_MASK;
        if (!rx_active) begin
            if (n == 0) begin
                r.status = ST_ERROR;
            end else if (kind == TYPE_SINGLE) begin
                if (nib > SF_MAX_DATA || n <= nib) begin
                    r.status = ST_ERROR;
                end else if (LEN_W'(nib) > rx_capacity) begin
                    r.status  = ST_TOO_LONG;
                    r.msg_len = LEN_W'(nib);
                end else begin
                    r.status  = ST_DONE;
                    r.msg_len = LEN_W'(nib);
                    r.count   = nib[2:0];
                end
            end else if (kind == TYPE_FIRST) begin
                total = {nib, f.bytes[1]};
                if (n < FRAME_MAX) begin
                    r.status = ST_ERROR;
                end else if (total <= SF_MAX_DATA || total > MAX_MESSAGE
                             || total > rx_capacity) begin
                    r.status  = ST_TOO_LONG;
                    r.flow    = FLOW_OVERFLOW;
                    r.msg_len = total;
                end else begin
                    rx_active = 1'b1;
                    rx_total  = total;
                    rx_got    = LEN_W'(FF_DATA);
                    rx_seq    = SEQ_START;
                    r.status  = ST_PROGRESS;
                    r.flow    = FLOW_CTS;
                    r.msg_len = total;
                    r.count   = FF_DATA;
                    from      = 2;
                end
            end else begin
                r.status = ST_ERROR;
            end
        end else begin
            total     = rx_total;
            r.msg_len = total;
            due       = (total > rx_got) ? total - rx_got : '0;
            if (due > CF_MAX_DATA) due = LEN_W'(CF_MAX_DATA);
            if (kind != TYPE_CONSEC || nib != rx_seq || n <= due) begin
                go_idle();
                r.status = ST_ERROR;
            end else begin
                rx_got   = rx_got + due;
                rx_seq   = rx_seq + 4'd1;
                r.count  = due[2:0];
                r.status = ST_PROGRESS;
                if (rx_got >= total) begin
                    go_idle();
                    r.status = ST_DONE;
                end
            end
        end
        for (int k = 0; k < 7; k++) begin
            if (k < r.count) r.data[k] = f.bytes[from + k];
        end
        return r;
    endfunction

    function automatic t_frame make_frame(input logic [3:0] len, input logic [7:0] b0,
                                          input logic [7:0] b1, input logic [7:0] fill);
        t_frame f;
        f.len = len;
        for (int k = 0; k < 8; k++) f.bytes[k] = fill;
        f.bytes[0] = b0;
        f.bytes[1] = b1;
        return f;
    endfunction

    function automatic t_frame random_frame();
        t_frame f;
        f.len = 4'($urandom_range(0, 15));
        for (int k = 0; k < 8; k++) f.bytes[k] = 8'($urandom_range(0, 255));
        return f;
    endfunction

    function automatic logic [3:0] pick_len(input int lo);
        if ($urandom_range(0, 7) == 0) return 4'($urandom_range(9, 15));
        return 4'($urandom_range(lo, 8));
    endfunction

    task automatic send_frame(input t_frame f);
        @(negedge i_clk);
        if (tx_gaps && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'h0, f};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_results.push_back(predict_frame(f));
        items_sent++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [LEN_W-1:0] value);
        drain();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        rx_capacity = value;
    endtask

    // single or first frame, then consecutive frames while the message is open
    task automatic send_message(input logic [LEN_W-1:0] total, input bit use_first,
                                input int damage);
        t_frame f;
        int     due;
        f = random_frame();
        if (!use_first && total <= SF_MAX_DATA) begin
            f.bytes[0] = TYPE_SINGLE | {4'h0, total[3:0]};
            f.len      = pick_len(int'(total) + 1);
            if ($urandom_range(0, 99) < damage) f.len = 4'($urandom_range(0, total));
            send_frame(f);
        end else begin
            f.bytes[0] = TYPE_FIRST | {4'h0, total[11:8]};
            f.bytes[1] = total[7:0];
            f.len      = pick_len(8);
            if ($urandom_range(0, 99) < damage) f.len = 4'($urandom_range(0, 7));
            send_frame(f);
            while (rx_active) begin
                due = int'(rx_total - rx_got);
                if (due > CF_MAX_DATA) due = CF_MAX_DATA;
                f = random_frame();
                f.bytes[0] = TYPE_CONSEC | {4'h0, rx_seq};
                f.len      = pick_len(due + 1);
                if ($urandom_range(0, 99) < damage) begin
                    case ($urandom_range(0, 2))
                        0: begin
                            f.bytes[0][3:0] = rx_seq + 4'($urandom_range(1, 15));
                        end
                        1: begin
                            f.len = 4'($urandom_range(0, due));
                        end
                        default: begin
                            f.bytes[0][7:4] = $urandom_range(0, 1) ?
                                4'($urandom_range(0, 1)) : 4'($urandom_range(3, 15));
                        end
                    endcase
                end
                send_frame(f);
            end
        end
    endtask

    task automatic test_directed();
        send_frame(make_frame(4'd0, 8'h00, 8'h00, 8'h00));
        send_frame(make_frame(4'd15, TYPE_SINGLE | 8'h07, 8'hff, 8'hff));
        send_frame(make_frame(4'd1, TYPE_SINGLE, 8'hff, 8'hff));
        send_frame(make_frame(4'd8, TYPE_SINGLE | 8'h08, 8'h00, 8'h00));
        send_frame(make_frame(4'd3, TYPE_SINGLE | 8'h05, 8'h00, 8'h00));
        send_frame(make_frame(4'd7, TYPE_FIRST, 8'h14, 8'h55));
        send_frame(make_frame(4'd8, TYPE_FIRST, 8'h07, 8'haa));
        send_frame(make_frame(4'd8, TYPE_CONSEC | 8'h01, 8'h00, 8'h00));
        send_frame(make_frame(4'd8, 8'h30, 8'h00, 8'h00));
        send_frame(make_frame(4'd8, 8'hf3, 8'hff, 8'hff));
        send_frame(make_frame(4'd8, TYPE_FIRST, 8'h14, 8'hff));
        send_frame(make_frame(4'd8, TYPE_CONSEC | 8'h01, 8'h00, 8'h00));
        send_frame(make_frame(4'd8, TYPE_CONSEC | 8'h02, 8'hff, 8'hff));
        send_frame(make_frame(4'd8, TYPE_FIRST, 8'h14, 8'h3c));
        send_frame(make_frame(4'd8, TYPE_CONSEC | 8'h03, 8'h11, 8'h22));
        send_frame(make_frame(4'd8, TYPE_FIRST, 8'h14, 8'h5a));
        send_frame(make_frame(4'd3, TYPE_SINGLE | 8'h02, 8'h77, 8'h88));
        send_frame(make_frame(4'd8, TYPE_FIRST, 8'h14, 8'h01));
        send_frame(make_frame(4'd5, TYPE_CONSEC | 8'h01, 8'h80, 8'h7f));
        send_frame(make_frame(4'd12, TYPE_FIRST, 8'h09, 8'hc3));
        send_frame(make_frame(4'd4, TYPE_CONSEC | 8'h01, 8'h96, 8'h69));
        send_frame(make_frame(4'd8, TYPE_FIRST | 8'h0f, 8'hff, 8'hee));
        send_frame(make_frame(4'd8, TYPE_FIRST | 8'h00, 8'h20, 8'hdd));
    endtask

    task automatic test_capacity();
        logic [LEN_W-1:0] caps [5] = '{12'd0, 12'd1, 12'd7, 12'd8, 12'd300};
        foreach (caps[c]) begin
            write_capacity(caps[c]);
            for (int n = 0; n < 8; n++) send_message(LEN_W'(n), 1'b0, 0);
            send_message(caps[c], 1'b1, 0);
            send_message(caps[c] + 12'd1, 1'b1, 0);
        end
    endtask

    task automatic test_longest_message();
        write_capacity(CAP_RESET);
        send_message(LEN_W'(MAX_MESSAGE), 1'b1, 0);
    endtask

    task automatic test_output_stall();
        tx_gaps  = 1'b0;
        hold_off = 1'b1;
        repeat (12) send_message(LEN_W'($urandom_range(0, 7)), 1'b0, 0);
        tx_gaps = 1'b1;
    endtask

    task automatic test_random(input int target);
        int pick;
        while (items_sent < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                send_frame(random_frame());
            end else if (pick < 40) begin
                send_message(LEN_W'($urandom_range(0, 7)), pick < 13, 3);
            end else if (pick < 90) begin
                send_message(LEN_W'($urandom_range(8, 60)), 1'b1, 3);
            end else begin
                send_message(LEN_W'($urandom_range(61, 320)), 1'b1, 3);
            end
        end
    endtask

    always @(posedge i_clk) begin : check_result
        t_result seen;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen.data    = m_axis_tdata[55:0];
            seen.count   = m_axis_tdata[58:56];
            seen.msg_len = m_axis_tdata[70:59];
            seen.status  = t_status'(m_axis_tuser[1:0]);
            seen.flow    = t_flow'(m_axis_tuser[3:2]);
            if (pending_results.size() == 0) begin
                $error("unexpected result transfer");
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                for (int k = 0; k < 7; k++) begin
                    if (seen.data[k] !== want.data[k]) begin
                        $error("out_byte_%0d: expected %0h, got %0h", k,
                               want.data[k], seen.data[k]);
                        fail_count++;
                    end
                end
                if (seen.count !== want.count) begin
                    $error("out_count: expected %0d, got %0d", want.count, seen.count);
                    fail_count++;
                end
                if (seen.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, seen.status);
                    fail_count++;
                end
                if (seen.flow !== want.flow) begin
                    $error("flow_request: expected %0d, got %0d", want.flow, seen.flow);
                    fail_count++;
                end
                if (seen.msg_len !== want.msg_len) begin
                    $error("message_length: expected %0d, got %0d",
                           want.msg_len, seen.msg_len);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && ((s_axis_tvalid && s_axis_tready) ||
                        (m_axis_tvalid && m_axis_tready))) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_off = 1'b0;
            end else if (rx_gaps && $urandom_range(0, 4) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(0, 2)) @(negedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        stall_cycles  = 0;
        items_sent    = 0;
        fail_count    = 0;
        tx_gaps       = 1'b1;
        rx_gaps       = 1'b1;
        hold_off      = 1'b0;
        rx_capacity   = CAP_RESET;
        go_idle();
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_capacity();
        test_longest_message();
        test_output_stall();
        write_capacity(12'd200);
        test_random(1000);
        write_capacity(CAP_RESET);
        test_random(1250);
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        test_random(1400);

        drain();
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
